>>> hw/rtl/assert_macros.svh
// Assertion helpers; define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> hw/rtl/tsu_pkg.sv
package tsu_pkg;

  localparam int CHANNELS  = 25;
  localparam int CH_W      = 5;
  localparam int STAMP_W   = 24;
  localparam int DEAD_W    = 16;
  localparam int COUNT_W   = 32;
  localparam int PERIOD_W  = 16;
  localparam int WAIT_W    = 25;
  localparam int RATIO_W   = 32;
  localparam int NUM_W     = 33;
  localparam int DIV_CNT_W = 6;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROLL_THR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_MASK = 2'd1;

  localparam logic [STAMP_W-1:0] ROLL_THR_RST   = 24'd2048;
  localparam logic [STAMP_W-1:0] ALIGN_MASK_RST = 24'hFFFFFF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DIV,
    ST_PUSH
  } state_t;

  typedef struct packed {
    logic load;
    logic calc;
    logic div_start;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic chan_ok;
    logic div_busy;
  } stat_t;

endpackage

>>> hw/rtl/tsu_in_if.sv
interface tsu_in_if import tsu_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CH_W-1:0]     channel;
  logic [STAMP_W-1:0]  stamp;
  logic [DEAD_W-1:0]   dead_count;

  modport source (output valid, channel, stamp, dead_count, input ready);
  modport sink   (input valid, channel, stamp, dead_count, output ready);
endinterface

>>> hw/rtl/tsu_out_if.sv
interface tsu_out_if import tsu_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CH_W-1:0]          channel_out;
  logic [COUNT_W-1:0]       packet_number;
  logic                     bad_flag;
  logic [STAMP_W-1:0]       fixed_stamp;
  logic [STAMP_W-1:0]       align_time;
  logic [PERIOD_W-1:0]      period;
  logic signed [WAIT_W-1:0] wait_ticks;
  logic [RATIO_W-1:0]       dead_frac;
  logic                     ratio_saturated;

  modport source (output valid, channel_out, packet_number, bad_flag, fixed_stamp,
                  align_time, period, wait_ticks, dead_frac, ratio_saturated,
                  input ready);
  modport sink   (input valid, channel_out, packet_number, bad_flag, fixed_stamp,
                  align_time, period, wait_ticks, dead_frac, ratio_saturated,
                  output ready);
endinterface

>>> hw/rtl/tsu_cfg_if.sv
interface tsu_cfg_if import tsu_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [STAMP_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/module_timestamp_unwrap.sv
// Per-channel timestamp unwrapper for 25 detector modules. Each input beat
// (channel, 24-bit stamp, 16-bit dead counter) yields one result beat with
// the packet number, zero-repaired stamp, masked align time, rollover
// period, signed wait and Q16.16 dead ratio; beats for channels 25..31 are
// taken and dropped. One packet occupies the block for these steps: accept,
// state lookup and update, the bit-serial restoring divider that forms
// the dead ratio, and the load of the output register. The output
// register frees the core, so the next packet is taken while a result
// still waits. Config writes are always ready and must only be issued
// while the block is idle.
`include "assert_macros.svh"

module module_timestamp_unwrap import tsu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  tsu_in_if.sink    in_bus,
  tsu_out_if.source out_bus,
  tsu_cfg_if.sink   cfg_bus
);

  cmd_t   cmd;
  stat_t  stat;
  state_t state;

  assign cfg_bus.ready = 1'b1;

  tsu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_ready  (in_bus.ready),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .stat      (stat),
    .cmd       (cmd),
    .state     (state)
  );

  tsu_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_channel      (in_bus.channel),
    .in_stamp        (in_bus.stamp),
    .in_dead_count   (in_bus.dead_count),
    .cfg_we          (cfg_bus.valid),
    .cfg_index       (cfg_bus.index),
    .cfg_data        (cfg_bus.data),
    .channel_out     (out_bus.channel_out),
    .packet_number   (out_bus.packet_number),
    .bad_flag        (out_bus.bad_flag),
    .fixed_stamp     (out_bus.fixed_stamp),
    .align_time      (out_bus.align_time),
    .period          (out_bus.period),
    .wait_ticks      (out_bus.wait_ticks),
    .dead_frac       (out_bus.dead_frac),
    .ratio_saturated (out_bus.ratio_saturated)
  );

  `ASSERT_IMPL(a_ready_div_idle, clk, rst_n, in_bus.ready, !stat.div_busy)
  `ASSERT_NEXT(a_div_runs, clk, rst_n, cmd.div_start, stat.div_busy && (state == ST_DIV))
  `ASSERT_IMPL(a_no_overwrite, clk, rst_n, cmd.out_load, !out_bus.valid || out_bus.ready)
  `ASSERT_IMPL(a_bad_wait_nonzero, clk, rst_n, out_bus.valid && out_bus.bad_flag, out_bus.wait_ticks != 0)

endmodule

>>> hw/rtl/tsu_div.sv
module tsu_div import tsu_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [NUM_W-1:0]   num,
  input  logic [STAMP_W-1:0] den,
  output logic               busy,
  output logic [NUM_W-1:0]   quo
);

  logic                 busy_r, busy_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [STAMP_W:0]     rem_r, rem_nxt;
  logic [NUM_W-1:0]     quo_r, quo_nxt;
  logic [STAMP_W-1:0]   den_r;
  logic [STAMP_W:0]     trial;
  logic                 ge;

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial    = {rem_r[STAMP_W-1:0], quo_r[NUM_W-1]};
    ge       = trial >= {1'b0, den_r};
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = num;
    end else if (busy_r) begin
      rem_nxt = ge ? trial - {1'b0, den_r} : trial;
      quo_nxt = {quo_r[NUM_W-2:0], ge};
      cnt_nxt = cnt_r + DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(NUM_W - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      den_r <= den;
    end
  end

  assign busy = busy_r;
  assign quo  = quo_r;

endmodule

>>> hw/rtl/tsu_dp.sv
module tsu_dp import tsu_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cmd_t                     cmd,
  output stat_t                    stat,
  input  logic [CH_W-1:0]          in_channel,
  input  logic [STAMP_W-1:0]       in_stamp,
  input  logic [DEAD_W-1:0]        in_dead_count,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [STAMP_W-1:0]       cfg_data,
  output logic [CH_W-1:0]          channel_out,
  output logic [COUNT_W-1:0]       packet_number,
  output logic                     bad_flag,
  output logic [STAMP_W-1:0]       fixed_stamp,
  output logic [STAMP_W-1:0]       align_time,
  output logic [PERIOD_W-1:0]      period,
  output logic signed [WAIT_W-1:0] wait_ticks,
  output logic [RATIO_W-1:0]       dead_frac,
  output logic                     ratio_saturated
);

  logic [STAMP_W-1:0] thr_r, mask_r;
  logic [CH_W-1:0]    ch_r;
  logic [STAMP_W-1:0] stamp_r;
  logic [DEAD_W-1:0]  dead_r;

  logic [CHANNELS-1:0] seen_r;
  logic [STAMP_W-1:0]  last_stamp_r [CHANNELS];
  logic [PERIOD_W-1:0] roll_cnt_r   [CHANNELS];
  logic [DEAD_W-1:0]   last_dead_r  [CHANNELS];
  logic [COUNT_W-1:0]  pkt_cnt_r    [CHANNELS];

  // per-item results held between calc and output load
  logic                first_r, bad_r;
  logic [CH_W-1:0]     res_ch_r;
  logic [STAMP_W-1:0]  fixed_r;
  logic [PERIOD_W-1:0] period_r;
  logic [WAIT_W-1:0]   wait_r;
  logic [COUNT_W-1:0]  pnum_r;

  logic                first, bad, roll;
  logic [STAMP_W-1:0]  l_stamp, fixed;
  logic [STAMP_W+1:0]  diff, thr_sum, wait_ext;
  logic [WAIT_W-1:0]   wait_v;
  logic [PERIOD_W-1:0] l_roll, period_v;
  logic [COUNT_W-1:0]  pnum;
  logic [DEAD_W-1:0]   d16;
  logic [NUM_W-1:0]    num;
  logic                div_busy;
  logic [NUM_W-1:0]    quo;
  logic                wait_pos;

  assign stat.chan_ok  = {1'b0, in_channel} < (CH_W + 1)'(CHANNELS);
  assign stat.div_busy = div_busy;

  always_comb begin
    first    = !seen_r[ch_r];
    l_stamp  = last_stamp_r[ch_r];
    l_roll   = roll_cnt_r[ch_r];
    bad      = !first && (stamp_r == '0);
    fixed    = bad ? l_stamp + STAMP_W'(1) : stamp_r;
    diff     = {2'b00, fixed} - {2'b00, l_stamp};
    thr_sum  = diff + {2'b00, thr_r};
    roll     = !first && thr_sum[STAMP_W+1];
    wait_ext = roll ? diff + (STAMP_W + 2)'(1 << STAMP_W) : diff;
    wait_v   = first ? '0 : wait_ext[WAIT_W-1:0];
    pnum     = first ? '0 : pkt_cnt_r[ch_r];
    if (first) begin
      period_v = '0;
    end else if (roll && (l_roll != '1)) begin
      period_v = l_roll + PERIOD_W'(1);
    end else begin
      period_v = l_roll;
    end
    // zero or negative dead difference wraps to 1..65536
    d16 = dead_r - last_dead_r[ch_r];
    num = {(d16 == '0), d16, 16'h0000};
  end

  tsu_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (num),
    .den   (wait_v[STAMP_W-1:0]),
    .busy  (div_busy),
    .quo   (quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= ROLL_THR_RST;
      mask_r <= ALIGN_MASK_RST;
      seen_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ROLL_THR:   thr_r  <= cfg_data;
          CFG_ALIGN_MASK: mask_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.calc) begin
        seen_r[ch_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ch_r    <= in_channel;
      stamp_r <= in_stamp;
      dead_r  <= in_dead_count;
    end
    if (cmd.calc) begin
      last_stamp_r[ch_r] <= fixed;
      roll_cnt_r[ch_r]   <= period_v;
      last_dead_r[ch_r]  <= dead_r;
      pkt_cnt_r[ch_r]    <= pnum + COUNT_W'(1);
      first_r            <= first;
      bad_r              <= bad;
      res_ch_r           <= ch_r;
      fixed_r            <= fixed;
      period_r           <= period_v;
      wait_r             <= wait_v;
      pnum_r             <= pnum;
    end
  end

  assign wait_pos = !wait_r[WAIT_W-1] && (wait_r != '0);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      channel_out   <= res_ch_r;
      packet_number <= pnum_r;
      bad_flag      <= bad_r;
      fixed_stamp   <= fixed_r;
      align_time    <= fixed_r & mask_r;
      period        <= period_r;
      wait_ticks    <= signed'(wait_r);
      if (first_r) begin
        dead_frac       <= '0;
        ratio_saturated <= 1'b0;
      end else if (!wait_pos || quo[NUM_W-1]) begin
        dead_frac       <= '1;
        ratio_saturated <= 1'b1;
      end else begin
        dead_frac       <= quo[RATIO_W-1:0];
        ratio_saturated <= 1'b0;
      end
    end
  end

endmodule

>>> hw/rtl/tsu_ctrl.sv
module tsu_ctrl import tsu_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  output logic   out_valid,
  input  logic   out_ready,
  input  stat_t  stat,
  output cmd_t   cmd,
  output state_t state
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_free  = !out_valid_r || out_ready;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (stat.chan_ok) begin
            state_nxt = ST_CALC;
          end
        end
      end
      ST_CALC: begin
        cmd.calc      = 1'b1;
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIV;
      end
      ST_DIV: begin
        if (!stat.div_busy) begin
          if (out_free) begin
            cmd.out_load = 1'b1;
            state_nxt    = ST_IDLE;
          end else begin
            state_nxt = ST_PUSH;
          end
        end
      end
      ST_PUSH: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    priority if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;
  assign state     = state_r;

endmodule
